// File: design/robah_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package robah_pkg;

    localparam int MAX_BOXES     = 64;
    localparam int WORDS_PER_BOX = 15;
    localparam int FRAC_BITS     = 16;
    localparam int BOX_WORDS     = MAX_BOXES * WORDS_PER_BOX;
    localparam int ADDR_W        = $clog2(BOX_WORDS);
    // distance numerators and denominators (2*dot plus length) fit in 52 bits
    localparam int NUM_W         = 52;
    localparam int DVD_W         = NUM_W + FRAC_BITS;
    localparam int QUO_W         = 62;

    localparam logic [63:0] T_SAT = 64'h3FFF_FFFF_FFFF_FFFF;

    localparam logic [3:0] WORD_BAD = 4'd15;

    typedef enum logic [0:0] {
        REG_BOX_COUNT = 1'b0,
        REG_THRESHOLD = 1'b1
    } reg_index_t;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_FETCH = 9'b000000010,
        S_MUL   = 9'b000000100,
        S_CHECK = 9'b000001000,
        S_DIV1  = 9'b000010000,
        S_DIV2  = 9'b000100000,
        S_UPD   = 9'b001000000,
        S_NEXT  = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

endpackage
`default_nettype wire

// File: design/robah_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface robah_query_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [5:0]  box_slot;
    logic [3:0]  word_slot;
    logic signed [31:0] word_value;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;

    modport source (output valid, kind, box_slot, word_slot, word_value,
                    dir_x, dir_y, dir_z, input ready);
    modport sink (input valid, kind, box_slot, word_slot, word_value,
                  dir_x, dir_y, dir_z, output ready);
endinterface

interface robah_result_if;
    logic       valid;
    logic       ready;
    logic       hit;
    logic [5:0] first_box;

    modport source (output valid, hit, first_box, input ready);
    modport sink (input valid, hit, first_box, output ready);
endinterface
`default_nettype wire

// File: design/robah_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module robah_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 960
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write one word, read one word with registered output
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// File: design/robah_div.sv
`timescale 1ns / 1ps
`default_nettype none
module robah_div import robah_pkg::*; (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [NUM_W-1:0] num,
    input  wire logic signed [NUM_W-1:0] den,
    output      logic                    done,
    output      logic signed [63:0]      quo
);

    localparam int CNT_W = $clog2(DVD_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             neg_reg, neg_next;
    logic             sat_reg, sat_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [NUM_W-1:0] ad_reg, ad_next;
    logic [NUM_W-1:0] rem_reg, rem_next;
    logic [QUO_W-1:0] q_reg, q_next;

    logic [NUM_W:0]   rem_sh;
    logic [NUM_W:0]   diff;
    logic             qbit;
    logic [NUM_W-1:0] an;
    logic [63:0]      mag;

    assign an     = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff   = rem_sh - {1'b0, ad_reg};
    assign qbit   = (rem_sh >= {1'b0, ad_reg});

    // one quotient bit per cycle, restoring
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        sat_next  = sat_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        ad_next   = ad_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        if (start)
        begin
            busy_next = 1'b1;
            neg_next  = num[NUM_W-1] != den[NUM_W-1];
            sat_next  = 1'b0;
            cnt_next  = '0;
            dvd_next  = {an, {FRAC_BITS{1'b0}}};
            ad_next   = den[NUM_W-1] ? NUM_W'(-den) : NUM_W'(den);
            rem_next  = '0;
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            rem_next = qbit ? diff[NUM_W-1:0] : rem_sh[NUM_W-1:0];
            q_next   = {q_reg[QUO_W-2:0], qbit};
            // bits at weight 2^62 and above saturate
            if (qbit && (cnt_reg < CNT_W'(DVD_W - QUO_W)))
            begin
                sat_next = 1'b1;
            end
            if (cnt_reg == CNT_W'(DVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        sat_reg <= sat_next;
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        ad_reg  <= ad_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
    end

    assign mag  = sat_reg ? T_SAT : {2'b00, q_reg};
    assign quo  = neg_reg ? -$signed(mag) : $signed(mag);
    assign done = done_reg;

endmodule
`default_nettype wire

// File: design/ray_oriented_box_any_hit.sv
`timescale 1ns / 1ps
`default_nettype none
// Ray versus oriented-box any-hit tester. Boxes are loaded one word at a time
// (kind 0) into a 960-word table; a query (kind 1) casts a ray from the origin
// and tests boxes 0..box_count-1 in order, returning hit and the first hit
// index (one result word per query, none per load). Q16.16 throughout.
// A query is dominated by the shared bit-serial divider (two distances per
// axis, none when the axis is parallel; a rejected box skips its remaining
// axes); one shared 32x32 multiplier forms the six dot-product terms of each
// axis. The input is not ready while a query runs. Registers: box_count at
// byte 0, parallel_threshold at byte 4.
module ray_oriented_box_any_hit import robah_pkg::*; (
    input  wire logic        clk,
    input  wire logic        rst_n,
    robah_query_if.sink      query,
    robah_result_if.source   result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    state_t state_reg, state_next;
    logic [6:0]  box_count_reg, box_count_next;
    logic [16:0] thr_reg, thr_next;
    logic signed [31:0] dir_reg [3];
    logic signed [31:0] dir_next [3];
    logic signed [31:0] c_reg [3];
    logic signed [31:0] c_next [3];
    logic signed [31:0] a_reg [3];
    logic signed [31:0] a_next [3];
    logic signed [31:0] len_reg, len_next;
    logic [6:0]  box_reg, box_next;
    logic [6:0]  n_reg, n_next;
    logic [1:0]  axis_reg, axis_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        fctr_reg, fctr_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [NUM_W-1:0] num_reg, num_next;
    logic signed [NUM_W-1:0] den_reg, den_next;
    logic signed [63:0] tmin_reg, tmin_next;
    logic signed [63:0] tmax_reg, tmax_next;
    logic signed [63:0] t1_reg, t1_next;
    logic        res_hit_reg, res_hit_next;
    logic [5:0]  res_first_reg, res_first_next;
    logic        out_valid_reg, out_valid_next;
    logic        hit_reg, hit_next;
    logic [5:0]  first_reg, first_next;

    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [31:0]       rd_data;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              cfg_wr;
    logic              in_acc;
    logic              div_start;
    logic signed [NUM_W-1:0] div_num;
    logic              div_done;
    logic signed [63:0] div_quo;

    logic [ADDR_W-1:0] box_base;
    logic [3:0]        offset;
    logic [1:0]        cap_idx;
    logic [1:0]        op_idx;
    logic signed [31:0] op_a;
    logic signed [NUM_W-1:0] term;
    logic signed [NUM_W-1:0] n2, d2, lenx, ad2, thr2;
    logic              par;
    logic              par_miss;
    logic signed [63:0] lo, hi, tmin_new, tmax_new;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (reg_index_t'(paddr[2]) == REG_THRESHOLD) ? {15'd0, thr_reg}
                                                              : {25'd0, box_count_reg};

    assign query.ready   = (state_reg == S_IDLE);
    assign in_acc        = query.valid && query.ready;
    assign result.valid  = out_valid_reg;
    assign result.hit    = hit_reg;
    assign result.first_box = first_reg;

    // box table write on loads
    assign wr_en   = in_acc && !query.kind && (query.word_slot != WORD_BAD);
    assign wr_addr = {query.box_slot, 4'd0} - {4'd0, query.box_slot}
                     + ADDR_W'(query.word_slot);

    // table read address for the current fetch
    assign box_base = {box_reg[5:0], 4'd0} - {4'd0, box_reg[5:0]};
    assign offset   = fctr_reg ? {1'b0, cnt_reg}
                    : (cnt_reg < 3'd3) ? 4'd3 + 4'(axis_reg) * 4'd3 + 4'(cnt_reg)
                                       : 4'd12 + 4'(axis_reg);
    assign rd_addr  = box_base + ADDR_W'(offset);
    assign cap_idx  = 2'(cnt_reg - 3'd1);

    robah_ram #(.WIDTH(32), .DEPTH(BOX_WORDS)) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (query.word_value),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // multiplier operands: center terms first, then direction terms
    assign op_idx = (cnt_reg < 3'd3) ? cnt_reg[1:0] : 2'(cnt_reg - 3'd3);
    assign op_a   = (cnt_reg < 3'd3) ? c_reg[op_idx] : dir_reg[op_idx];
    assign term   = NUM_W'(prod_reg >>> FRAC_BITS);

    // slab values, doubled to keep half lengths exact
    assign n2   = num_reg <<< 1;
    assign d2   = den_reg <<< 1;
    assign lenx = NUM_W'(len_reg);
    assign ad2  = d2[NUM_W-1] ? -d2 : d2;
    assign thr2 = NUM_W'({thr_reg, 1'b0});
    assign par  = (d2 == '0) || (ad2 < thr2);
    assign par_miss = (n2 < -lenx) || (n2 > lenx);

    assign lo       = (t1_reg < div_quo) ? t1_reg : div_quo;
    assign hi       = (t1_reg < div_quo) ? div_quo : t1_reg;
    assign tmin_new = (lo > tmin_reg) ? lo : tmin_reg;
    assign tmax_new = (hi < tmax_reg) ? hi : tmax_reg;

    robah_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (d2),
        .done  (div_done),
        .quo   (div_quo)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        box_count_next = box_count_reg;
        thr_next       = thr_reg;
        dir_next       = dir_reg;
        c_next         = c_reg;
        a_next         = a_reg;
        len_next       = len_reg;
        box_next       = box_reg;
        n_next         = n_reg;
        axis_next      = axis_reg;
        cnt_next       = cnt_reg;
        fctr_next      = fctr_reg;
        prod_next      = prod_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        tmin_next      = tmin_reg;
        tmax_next      = tmax_reg;
        t1_next        = t1_reg;
        res_hit_next   = res_hit_reg;
        res_first_next = res_first_reg;
        out_valid_next = out_valid_reg;
        hit_next       = hit_reg;
        first_next     = first_reg;
        rd_en          = 1'b0;
        div_start      = 1'b0;
        div_num        = n2 - lenx;

        if (cfg_wr)
        begin
            unique case (reg_index_t'(paddr[2]))
                REG_BOX_COUNT: box_count_next = pwdata[6:0];
                REG_THRESHOLD: thr_next = pwdata[16:0];
                default: ;
            endcase
        end

        // drop the result word once taken
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && query.kind)
                begin
                    dir_next[0] = query.dir_x;
                    dir_next[1] = query.dir_y;
                    dir_next[2] = query.dir_z;
                    n_next      = (box_count_reg > 7'(MAX_BOXES)) ? 7'(MAX_BOXES)
                                                                  : box_count_reg;
                    box_next    = '0;
                    axis_next   = '0;
                    cnt_next    = '0;
                    fctr_next   = 1'b1;
                    tmin_next   = '0;
                    tmax_next   = T_SAT;
                    res_hit_next   = 1'b0;
                    res_first_next = '0;
                    if (box_count_reg == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
            begin
                rd_en = fctr_reg ? (cnt_reg < 3'd3) : (cnt_reg < 3'd4);
                if (cnt_reg != '0)
                begin
                    if (fctr_reg)
                    begin
                        c_next[cap_idx] = rd_data;
                    end
                    else if (cnt_reg == 3'd4)
                    begin
                        len_next = rd_data;
                    end
                    else
                    begin
                        a_next[cap_idx] = rd_data;
                    end
                end
                if (fctr_reg && (cnt_reg == 3'd3))
                begin
                    fctr_next = 1'b0;
                    cnt_next  = '0;
                end
                else if (!fctr_reg && (cnt_reg == 3'd4))
                begin
                    cnt_next   = '0;
                    num_next   = '0;
                    den_next   = '0;
                    state_next = S_MUL;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            S_MUL:
            begin
                prod_next = op_a * a_reg[op_idx];
                if (cnt_reg != '0)
                begin
                    if (cnt_reg <= 3'd3)
                    begin
                        num_next = num_reg + term;
                    end
                    else
                    begin
                        den_next = den_reg + term;
                    end
                end
                if (cnt_reg == 3'd6)
                begin
                    state_next = S_CHECK;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            S_CHECK:
            begin
                if (par)
                begin
                    if (par_miss)
                    begin
                        state_next = S_NEXT;
                    end
                    else if (axis_reg == 2'd2)
                    begin
                        res_hit_next   = 1'b1;
                        res_first_next = box_reg[5:0];
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        cnt_next   = '0;
                        state_next = S_FETCH;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = n2 - lenx;
                    state_next = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (div_done)
                begin
                    t1_next    = div_quo;
                    div_start  = 1'b1;
                    div_num    = n2 + lenx;
                    state_next = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (div_done)
                begin
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                tmin_next = tmin_new;
                tmax_next = tmax_new;
                if (tmin_new > tmax_new)
                begin
                    state_next = S_NEXT;
                end
                else if (axis_reg == 2'd2)
                begin
                    res_hit_next   = 1'b1;
                    res_first_next = box_reg[5:0];
                    state_next     = S_DONE;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    cnt_next   = '0;
                    state_next = S_FETCH;
                end
            end
            S_NEXT:
            begin
                // advance to the next box or finish with no hit
                if (box_reg + 7'd1 >= n_reg)
                begin
                    res_hit_next   = 1'b0;
                    res_first_next = '0;
                    state_next     = S_DONE;
                end
                else
                begin
                    box_next   = box_reg + 7'd1;
                    axis_next  = '0;
                    cnt_next   = '0;
                    fctr_next  = 1'b1;
                    tmin_next  = '0;
                    tmax_next  = T_SAT;
                    state_next = S_FETCH;
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    hit_next       = res_hit_reg;
                    first_next     = res_first_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            box_count_reg <= '0;
            thr_reg       <= 17'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            box_count_reg <= box_count_next;
            thr_reg       <= thr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dir_reg       <= dir_next;
        c_reg         <= c_next;
        a_reg         <= a_next;
        len_reg       <= len_next;
        box_reg       <= box_next;
        n_reg         <= n_next;
        axis_reg      <= axis_next;
        cnt_reg       <= cnt_next;
        fctr_reg      <= fctr_next;
        prod_reg      <= prod_next;
        num_reg       <= num_next;
        den_reg       <= den_next;
        tmin_reg      <= tmin_next;
        tmax_reg      <= tmax_next;
        t1_reg        <= t1_next;
        res_hit_reg   <= res_hit_next;
        res_first_reg <= res_first_next;
        hit_reg       <= hit_next;
        first_reg     <= first_next;
    end

endmodule
`default_nettype wire
